/* rtl/dhash_pkg.sv */
package dhash_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int GRID_COLS = 9;
    localparam int GRID_ROWS = 8;
    localparam int GIDX_W    = 4;
    localparam int LUMA_W    = 8;
    localparam int HASH_W    = 64;
    localparam int SUM_W     = 18;
    localparam int NSUM_W    = 15;
    localparam int CFG_IDX_W = 1;

    localparam int WIDTH_RESET  = 9;
    localparam int HEIGHT_RESET = 8;

    // settle count loaded on reset and on a dimension change; sample positions have settled once it runs out
    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_W      = 2;

    // luma weights, scaled by 1000
    localparam int LUMA_B = 114;
    localparam int LUMA_G = 587;
    localparam int LUMA_R = 299;

    // floor(n / 9) for n < 2**16, and floor(n / 125) for n < 2**15
    localparam int DIV9_MULT    = 58255;
    localparam int DIV9_SHIFT   = 19;
    localparam int DIV125_MULT  = 33555;
    localparam int DIV125_SHIFT = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [DIM_W-1:0] dim_t;

    typedef struct packed {
        pos_t [GRID_COLS-1:0] col;
        pos_t [GRID_ROWS-1:0] row;
        dim_t                 width;
        dim_t                 height;
        logic                 busy;
    } geom_t;

    typedef struct packed {
        logic [NSUM_W-1:0]    nsum;
        logic [GRID_COLS-1:0] wmask;
        logic [GIDX_W-1:0]    rows_done;
        logic                 last;
    } work_t;

    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/difference_hash_from_pixels.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// pixel    | pixel_valid / pixel_ready  | blue, green, red (8 bits each)
// hash     | hash_valid / hash_ready    | hash_value (64 bits)
// config   | cfg_write (no wait)        | cfg_index (0 width, 1 height), cfg_data
//
// One pixel word per cycle while pixel_ready is high; a word passes input register,
// weighted-sum register and luma/compare stage, and the hash is registered as the last pixel's word leaves that stage.
// A pending hash does not stall pixels; only a later frame end waits for it to drain.
// After reset and after every dimension write, pixel_ready stays low while the sample
// position registers (multiply, then divide by 18 or 16) settle.
// A dimension write restarts the frame.
module difference_hash_from_pixels
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dhash_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dhash_pkg::DIM_W-1:0]     cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [dhash_pkg::LUMA_W-1:0]    blue,
    input  logic [dhash_pkg::LUMA_W-1:0]    green,
    input  logic [dhash_pkg::LUMA_W-1:0]    red,
    output logic                            hash_valid,
    input  logic                            hash_ready,
    output logic [dhash_pkg::HASH_W-1:0]    hash_value
);

    dhash_pkg::geom_t geom;
    dhash_pkg::work_t s2;
    logic             s2_valid;
    logic             take;

    dhash_targets u_targets
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    dhash_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .geom        (geom),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .take        (take),
        .s2_valid    (s2_valid),
        .s2          (s2)
    );

    dhash_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .s2_valid   (s2_valid),
        .s2         (s2),
        .take       (take),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

endmodule

/* rtl/dhash_targets.sv */
module dhash_targets
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dhash_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dhash_pkg::DIM_W-1:0]     cfg_data,
    output dhash_pkg::geom_t                geom
);

    localparam int CPROD_W = 17;
    localparam int RPROD_W = 16;
    localparam int QMUL_W  = 32;

    dhash_pkg::dim_t width_reg;
    dhash_pkg::dim_t width_next;
    dhash_pkg::dim_t height_reg;
    dhash_pkg::dim_t height_next;
    logic [dhash_pkg::SETTLE_W-1:0] settle_reg;
    logic [dhash_pkg::SETTLE_W-1:0] settle_next;

    logic [CPROD_W-1:0] col_prod_reg  [dhash_pkg::GRID_COLS];
    logic [CPROD_W-1:0] col_prod_next [dhash_pkg::GRID_COLS];
    logic [RPROD_W-1:0] row_prod_reg  [dhash_pkg::GRID_ROWS];
    logic [RPROD_W-1:0] row_prod_next [dhash_pkg::GRID_ROWS];
    dhash_pkg::pos_t    col_reg  [dhash_pkg::GRID_COLS];
    dhash_pkg::pos_t    col_next [dhash_pkg::GRID_COLS];
    dhash_pkg::pos_t    row_reg  [dhash_pkg::GRID_ROWS];
    dhash_pkg::pos_t    row_next [dhash_pkg::GRID_ROWS];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        settle_next = settle_reg;
        if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        if (cfg_write)
        begin
            if (cfg_index == dhash_pkg::REG_WIDTH)
            begin
                width_next = dhash_pkg::clamp_dim(cfg_data);
            end
            else
            begin
                height_next = dhash_pkg::clamp_dim(cfg_data);
            end
            settle_next = dhash_pkg::SETTLE_W'(dhash_pkg::SETTLE_CYCLES);
        end
    end

    // first stage: (2k+1) * size
    always_comb
    begin
        for (int k = 0; k < dhash_pkg::GRID_COLS; k++)
        begin
            col_prod_next[k] = CPROD_W'(width_reg) * CPROD_W'(2 * k + 1);
        end
        for (int k = 0; k < dhash_pkg::GRID_ROWS; k++)
        begin
            row_prod_next[k] = RPROD_W'(height_reg) * RPROD_W'(2 * k + 1);
        end
    end

    // second stage: divide by 18 or 16, clamp to the last pixel
    always_comb
    begin
        logic [QMUL_W-1:0]        q;
        dhash_pkg::dim_t          qd;
        dhash_pkg::dim_t          wm1;
        dhash_pkg::dim_t          hm1;
        wm1 = width_reg - 1'b1;
        hm1 = height_reg - 1'b1;
        for (int k = 0; k < dhash_pkg::GRID_COLS; k++)
        begin
            q  = QMUL_W'(col_prod_reg[k][CPROD_W-1:1]) * QMUL_W'(dhash_pkg::DIV9_MULT);
            qd = dhash_pkg::DIM_W'(q >> dhash_pkg::DIV9_SHIFT);
            col_next[k] = (qd > wm1) ? wm1[dhash_pkg::POS_W-1:0] : qd[dhash_pkg::POS_W-1:0];
        end
        for (int k = 0; k < dhash_pkg::GRID_ROWS; k++)
        begin
            qd = dhash_pkg::DIM_W'(row_prod_reg[k] >> 4);
            row_next[k] = (qd > hm1) ? hm1[dhash_pkg::POS_W-1:0] : qd[dhash_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dhash_pkg::DIM_W'(dhash_pkg::WIDTH_RESET);
            height_reg <= dhash_pkg::DIM_W'(dhash_pkg::HEIGHT_RESET);
            settle_reg <= dhash_pkg::SETTLE_W'(dhash_pkg::SETTLE_CYCLES);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            settle_reg <= settle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_prod_reg <= col_prod_next;
        row_prod_reg <= row_prod_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
    end

    always_comb
    begin
        for (int k = 0; k < dhash_pkg::GRID_COLS; k++)
        begin
            geom.col[k] = col_reg[k];
        end
        for (int k = 0; k < dhash_pkg::GRID_ROWS; k++)
        begin
            geom.row[k] = row_reg[k];
        end
        geom.width  = width_reg;
        geom.height = height_reg;
        geom.busy   = (settle_reg != '0);
    end

    a_settle_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (settle_reg == dhash_pkg::SETTLE_W'(dhash_pkg::SETTLE_CYCLES)))
        else $error("settle count not loaded after a write");

    a_width_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg != '0) && (width_reg <= dhash_pkg::DIM_W'(dhash_pkg::MAX_DIM)))
        else $error("stored width out of range");

    a_height_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (height_reg != '0) && (height_reg <= dhash_pkg::DIM_W'(dhash_pkg::MAX_DIM)))
        else $error("stored height out of range");

endmodule

/* rtl/dhash_front.sv */
module dhash_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  dhash_pkg::geom_t             geom,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  logic [dhash_pkg::LUMA_W-1:0] blue,
    input  logic [dhash_pkg::LUMA_W-1:0] green,
    input  logic [dhash_pkg::LUMA_W-1:0] red,
    input  logic                         take,
    output logic                         s2_valid,
    output dhash_pkg::work_t             s2
);

    dhash_pkg::pos_t                   col_reg;
    dhash_pkg::pos_t                   col_next;
    dhash_pkg::pos_t                   row_reg;
    dhash_pkg::pos_t                   row_next;
    logic [dhash_pkg::GIDX_W-1:0]      grid_idx_reg;
    logic [dhash_pkg::GIDX_W-1:0]      grid_idx_next;

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [dhash_pkg::LUMA_W-1:0]      s1_blue_reg;
    logic [dhash_pkg::LUMA_W-1:0]      s1_green_reg;
    logic [dhash_pkg::LUMA_W-1:0]      s1_red_reg;
    logic [dhash_pkg::GRID_COLS-1:0]   s1_wmask_reg;
    logic [dhash_pkg::GIDX_W-1:0]      s1_cnt_reg;
    logic                              s1_last_reg;

    logic                              s2_valid_reg;
    logic                              s2_valid_next;
    dhash_pkg::work_t                  s2_reg;
    dhash_pkg::work_t                  s2_next;

    logic                              in_fire;
    logic                              s2_free;
    logic                              s1_free;
    logic                              on_grid;
    logic                              end_row;
    logic                              last_pixel;
    logic [dhash_pkg::GRID_COLS-1:0]   wmask;
    logic [dhash_pkg::GIDX_W-1:0]      cnt;
    logic [dhash_pkg::SUM_W-1:0]       sum;

    assign s2_free     = !s2_valid_reg || take;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign pixel_ready = s1_free && !geom.busy;
    assign in_fire     = pixel_valid && pixel_ready;

    // where the incoming pixel falls on the grid
    always_comb
    begin
        on_grid = (grid_idx_reg < dhash_pkg::GIDX_W'(dhash_pkg::GRID_ROWS)) &&
                  (geom.row[grid_idx_reg[dhash_pkg::GIDX_W-2:0]] == row_reg);
        for (int k = 0; k < dhash_pkg::GRID_COLS; k++)
        begin
            wmask[k] = on_grid && (geom.col[k] == col_reg);
        end
        end_row    = ({1'b0, col_reg} + dhash_pkg::DIM_W'(1)) >= geom.width;
        last_pixel = end_row && (({1'b0, row_reg} + dhash_pkg::DIM_W'(1)) >= geom.height);
        // grid rows completed at the end of this pixel row
        cnt = '0;
        for (int j = 0; j < dhash_pkg::GRID_ROWS; j++)
        begin
            if (end_row && (dhash_pkg::GIDX_W'(j) >= grid_idx_reg) && (geom.row[j] == row_reg))
            begin
                cnt = cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        grid_idx_next = grid_idx_reg;
        if (in_fire)
        begin
            if (end_row)
            begin
                col_next = '0;
                if (last_pixel)
                begin
                    row_next      = '0;
                    grid_idx_next = '0;
                end
                else
                begin
                    row_next      = row_reg + 1'b1;
                    grid_idx_next = grid_idx_reg + cnt;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cfg_write)
        begin
            col_next      = '0;
            row_next      = '0;
            grid_idx_next = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_free)
        begin
            s1_valid_next = in_fire;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_free)
        begin
            s2_valid_next = s1_valid_reg;
        end
        sum = dhash_pkg::SUM_W'(s1_blue_reg)  * dhash_pkg::SUM_W'(dhash_pkg::LUMA_B) +
              dhash_pkg::SUM_W'(s1_green_reg) * dhash_pkg::SUM_W'(dhash_pkg::LUMA_G) +
              dhash_pkg::SUM_W'(s1_red_reg)   * dhash_pkg::SUM_W'(dhash_pkg::LUMA_R);
        s2_next.nsum      = sum[dhash_pkg::SUM_W-1:3];
        s2_next.wmask     = s1_wmask_reg;
        s2_next.rows_done = s1_cnt_reg;
        s2_next.last      = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            grid_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            grid_idx_reg <= grid_idx_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_blue_reg  <= blue;
            s1_green_reg <= green;
            s1_red_reg   <= red;
            s1_wmask_reg <= wmask;
            s1_cnt_reg   <= cnt;
            s1_last_reg  <= last_pixel;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        geom.busy |-> !pixel_ready)
        else $error("word accepted while sample positions settle");

    a_grid_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        grid_idx_reg <= dhash_pkg::GIDX_W'(dhash_pkg::GRID_ROWS))
        else $error("grid row index past the grid");

    a_frame_complete: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_pixel |->
            ((grid_idx_reg + cnt) == dhash_pkg::GIDX_W'(dhash_pkg::GRID_ROWS)))
        else $error("frame ends with grid rows missing");

endmodule

/* rtl/dhash_back.sv */
module dhash_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         s2_valid,
    input  dhash_pkg::work_t             s2,
    output logic                         take,
    output logic                         hash_valid,
    input  logic                         hash_ready,
    output logic [dhash_pkg::HASH_W-1:0] hash_value
);

    localparam int LMUL_W = 31;

    logic [dhash_pkg::LUMA_W-1:0] lumas_reg  [dhash_pkg::GRID_COLS];
    logic [dhash_pkg::LUMA_W-1:0] lumas_next [dhash_pkg::GRID_COLS];
    logic [dhash_pkg::HASH_W-1:0] acc_reg;
    logic [dhash_pkg::HASH_W-1:0] acc_next;
    logic [dhash_pkg::HASH_W-1:0] acc_done;
    logic                         hash_valid_reg;
    logic                         hash_valid_next;
    logic [dhash_pkg::HASH_W-1:0] hash_reg;

    logic [LMUL_W-1:0]                 lprod;
    logic [dhash_pkg::LUMA_W-1:0]      luma;
    logic [dhash_pkg::GRID_COLS-2:0]   bits;

    // hold the last word while the output is full and not drained
    assign take = s2_valid && !(s2.last && hash_valid_reg && !hash_ready);

    always_comb
    begin
        lprod = LMUL_W'(s2.nsum) * LMUL_W'(dhash_pkg::DIV125_MULT);
        luma  = dhash_pkg::LUMA_W'(lprod >> dhash_pkg::DIV125_SHIFT);
        for (int k = 0; k < dhash_pkg::GRID_COLS; k++)
        begin
            lumas_next[k] = s2.wmask[k] ? luma : lumas_reg[k];
        end
        // column 0 against column 1 lands in the MSB
        for (int k = 0; k < dhash_pkg::GRID_COLS - 1; k++)
        begin
            bits[dhash_pkg::GRID_COLS-2-k] = lumas_next[k] > lumas_next[k + 1];
        end
        acc_done = acc_reg;
        for (int i = 0; i < dhash_pkg::GRID_ROWS; i++)
        begin
            if (dhash_pkg::GIDX_W'(i) < s2.rows_done)
            begin
                acc_done = {acc_done[dhash_pkg::HASH_W-dhash_pkg::GRID_COLS:0], bits};
            end
        end
    end

    always_comb
    begin
        acc_next        = acc_reg;
        hash_valid_next = hash_valid_reg;
        if (hash_ready)
        begin
            hash_valid_next = 1'b0;
        end
        if (take)
        begin
            acc_next = s2.last ? '0 : acc_done;
            if (s2.last)
            begin
                hash_valid_next = 1'b1;
            end
        end
        if (cfg_write)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lumas_reg <= lumas_next;
        end
        if (take && s2.last)
        begin
            hash_reg <= acc_done;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        take && s2.last && hash_valid_reg |-> hash_ready)
        else $error("pending hash overwritten");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        take && s2.last |=> hash_valid_reg)
        else $error("finished frame gave no hash");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        take && s2.last |=> (acc_reg == '0))
        else $error("accumulator not cleared after a frame");

endmodule
